// ===== src/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared sizes and types for the Robin Hood hash insert core.
// ----------------------------------------------------------------------------
package rhh_pkg;

	localparam int TABLE_SLOTS = 1024;
	localparam int STORE_BYTES = 65536;

	localparam int KEY_W      = 32;
	localparam int LEN_W      = 8;
	localparam int OFF_W      = 16;
	localparam int CFG_W      = 11;
	localparam int IDX_W      = $clog2(TABLE_SLOTS);
	localparam int SLOT_CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int WP_W       = $clog2(STORE_BYTES + 1);

	// slot count after reset, clipped to the table size
	localparam int SLOTS_RESET = (TABLE_SLOTS < 1024) ? TABLE_SLOTS : 1024;

	// remainder unit: bits retired per cycle and cycles per operation
	localparam int MOD_BITS   = 4;
	localparam int MOD_CYCLES = KEY_W / MOD_BITS;
	localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

	typedef enum logic [1:0] {
		STS_INSERTED   = 2'd0,
		STS_PRESENT    = 2'd1,
		STS_TABLE_FULL = 2'd2,
		STS_STORE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] hash;
		logic [OFF_W-1:0] offset;
	} entry_t;

endpackage

// ===== src/rhh_mod.sv =====
// ----------------------------------------------------------------------------
// rhh_mod
// Multi-cycle remainder of a 32-bit hash by the active slot count,
// restoring division retiring a few dividend bits per cycle.
// ----------------------------------------------------------------------------
module rhh_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rhh_pkg::KEY_W-1:0]     dividend,
	input  logic [rhh_pkg::SLOT_CNT_W-1:0] divisor,
	output logic                          done,
	output logic [rhh_pkg::IDX_W-1:0]     rem
);
	import rhh_pkg::*;

	logic [KEY_W-1:0]     acc_q;
	logic [IDX_W-1:0]     r_q;
	logic [IDX_W-1:0]     r_nxt;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [IDX_W:0]       dv;

	assign dv = (IDX_W+1)'(divisor);

	always_comb begin
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] tr;
		tr = r_q;
		for (int j = 0; j < MOD_BITS; j++) begin
			t = {tr, acc_q[KEY_W-1-j]};
			if (t >= dv) begin
				t = t - dv;
			end
			tr = t[IDX_W-1:0];
		end
		r_nxt = tr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			r_q    <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			acc_q  <= dividend;
			r_q    <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			acc_q <= acc_q << MOD_BITS;
			r_q   <= r_nxt;
			cnt_q <= cnt_q + MOD_CNT_W'(1);
			if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

// ===== src/robin_hood_hash_insert_core.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_insert_core
// Robin Hood open-addressing insert over a table of key hashes held in one
// synchronous memory, with a string store write pointer.
// ----------------------------------------------------------------------------
// After reset the table is swept to empty, one slot a cycle, with busy high;
// configuration writes are taken throughout. One insert is handled at a time:
// start is taken while busy is low, and the result appears for one cycle on
// done, which cannot be held off. Each slot examined that holds another key
// costs a memory read, a check and a wait for the remainder (its home slot
// under the active slot count); the key's own home slot is first found with
// the remainder up front. When the search stops at a poorer resident, the
// table is scanned onward for an empty slot, a read and a check a slot, then
// the displacement chain walks on with a read, a check and a remainder a slot.
// A zero key answers on the next cycle.
module robin_hood_hash_insert_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rhh_pkg::KEY_W-1:0]      key_hash,
	input  logic [rhh_pkg::LEN_W-1:0]      string_length,
	output logic                           done,
	output logic [rhh_pkg::KEY_W-1:0]      returned_hash,
	output logic [1:0]                     status,
	output logic [rhh_pkg::OFF_W-1:0]      entry_offset,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rhh_pkg::CFG_W-1:0]      cfg_data
);
	import rhh_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_S_RD,
		ST_S_CHK,
		ST_S_DIST,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DECIDE,
		ST_I_RD,
		ST_I_CHK,
		ST_I_DIST
	} state_t;

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p,
			input logic [SLOT_CNT_W-1:0] s);
		if (SLOT_CNT_W'(p) + SLOT_CNT_W'(1) == s) begin
			return '0;
		end
		return p + IDX_W'(1);
	endfunction

	state_t                state_q;
	logic [KEY_W-1:0]      key_q;
	logic [LEN_W-1:0]      slen_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      stop_pos_q;
	logic [SLOT_CNT_W-1:0] step_q;
	logic [SLOT_CNT_W-1:0] d_q;
	logic                  place_empty_q;
	entry_t                car_q;
	entry_t                res_q;
	logic [WP_W-1:0]       wp_q;
	logic [SLOT_CNT_W-1:0] s_q;
	logic                  done_q;
	logic [KEY_W-1:0]      rhash_q;
	logic [1:0]            status_q;
	logic [OFF_W-1:0]      off_q;

	entry_t                tbl_mem [TABLE_SLOTS];
	entry_t                rd_data_q;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	entry_t                mem_wdata;

	logic                  mod_start;
	logic [KEY_W-1:0]      mod_dividend;
	logic                  mod_done;
	logic [IDX_W-1:0]      mod_rem;

	logic [IDX_W-1:0]      rdist;
	logic [SLOT_CNT_W:0]   dsum;
	logic [SLOT_CNT_W-1:0] dist_ext;
	logic                  step_last;
	logic [WP_W:0]         wp_sum;
	logic                  store_full;
	logic [OFF_W-1:0]      new_off;
	logic [SLOT_CNT_W-1:0] cfg_eff;

	// remainder unit, shared by the key's home slot and every resident whose distance is checked
	rhh_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (s_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// probe distance of the resident at pos_q, its home being mod_rem
	always_comb begin
		dsum = (SLOT_CNT_W+1)'(pos_q) + (SLOT_CNT_W+1)'(s_q)
			- (SLOT_CNT_W+1)'(mod_rem);
		if (pos_q >= mod_rem) begin
			rdist = pos_q - mod_rem;
		end else begin
			rdist = IDX_W'(dsum);
		end
		dist_ext = SLOT_CNT_W'(rdist);
	end

	assign step_last  = (step_q + SLOT_CNT_W'(1)) == s_q;
	assign wp_sum     = (WP_W+1)'(wp_q) + (WP_W+1)'(slen_q) + (WP_W+1)'(1);
	assign store_full = wp_sum > (WP_W+1)'(STORE_BYTES);
	assign new_off    = OFF_W'(wp_q);

	// clamp the written slot count to 1 .. TABLE_SLOTS
	always_comb begin
		if (cfg_data == '0) begin
			cfg_eff = SLOT_CNT_W'(1);
		end else if (32'(cfg_data) > 32'(TABLE_SLOTS)) begin
			cfg_eff = SLOT_CNT_W'(TABLE_SLOTS);
		end else begin
			cfg_eff = SLOT_CNT_W'(cfg_data);
		end
	end

	always_comb begin
		mod_start    = 1'b0;
		mod_dividend = rd_data_q.hash;
		mem_re       = 1'b0;
		mem_raddr    = pos_q;
		mem_we       = 1'b0;
		mem_waddr    = pos_q;
		mem_wdata    = car_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mod_dividend = key_hash;
				mod_start    = start && (key_hash != '0);
			end
			ST_S_RD, ST_SCAN_RD, ST_I_RD: begin
				mem_re = 1'b1;
			end
			ST_S_CHK: begin
				mod_start = (rd_data_q.hash != '0) && (rd_data_q.hash != key_q);
			end
			ST_DECIDE: begin
				mem_we           = !store_full;
				mem_waddr        = place_empty_q ? pos_q : stop_pos_q;
				mem_wdata.hash   = key_q;
				mem_wdata.offset = new_off;
			end
			ST_I_CHK: begin
				mem_we    = (rd_data_q.hash == '0);
				mod_start = (rd_data_q.hash != '0);
			end
			ST_I_DIST: begin
				mem_we = mod_done && (dist_ext < d_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= tbl_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			key_q         <= '0;
			slen_q        <= '0;
			pos_q         <= '0;
			stop_pos_q    <= '0;
			step_q        <= '0;
			d_q           <= '0;
			place_empty_q <= 1'b0;
			car_q         <= '0;
			res_q         <= '0;
			wp_q          <= '0;
			s_q           <= SLOT_CNT_W'(SLOTS_RESET);
			done_q        <= 1'b0;
			rhash_q       <= '0;
			status_q      <= STS_INSERTED;
			off_q         <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				s_q <= cfg_eff;
			end
			case (state_q)
				ST_CLEAR: begin
					if (pos_q == IDX_W'(TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						key_q  <= key_hash;
						slen_q <= string_length;
						if (key_hash == '0) begin
							done_q   <= 1'b1;
							rhash_q  <= '0;
							status_q <= STS_TABLE_FULL;
							off_q    <= '0;
						end else begin
							state_q <= ST_HOME;
						end
					end
				end
				ST_HOME: begin
					if (mod_done) begin
						pos_q   <= mod_rem;
						step_q  <= '0;
						state_q <= ST_S_RD;
					end
				end
				ST_S_RD: begin
					state_q <= ST_S_CHK;
				end
				ST_S_CHK: begin
					res_q <= rd_data_q;
					if (rd_data_q.hash == '0) begin
						place_empty_q <= 1'b1;
						state_q       <= ST_DECIDE;
					end else if (rd_data_q.hash == key_q) begin
						done_q   <= 1'b1;
						rhash_q  <= key_q;
						status_q <= STS_PRESENT;
						off_q    <= rd_data_q.offset;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_S_DIST;
					end
				end
				ST_S_DIST: begin
					if (mod_done) begin
						if (dist_ext < step_q) begin
							// poorer resident: remember it, then look for any empty slot
							stop_pos_q    <= pos_q;
							d_q           <= dist_ext;
							place_empty_q <= 1'b0;
						end
						if (step_last) begin
							done_q   <= 1'b1;
							rhash_q  <= '0;
							status_q <= STS_TABLE_FULL;
							off_q    <= '0;
							state_q  <= ST_IDLE;
						end else begin
							pos_q   <= next_pos(pos_q, s_q);
							step_q  <= step_q + SLOT_CNT_W'(1);
							state_q <= (dist_ext < step_q) ? ST_SCAN_RD : ST_S_RD;
						end
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (rd_data_q.hash == '0) begin
						state_q <= ST_DECIDE;
					end else if (step_last) begin
						done_q   <= 1'b1;
						rhash_q  <= '0;
						status_q <= STS_TABLE_FULL;
						off_q    <= '0;
						state_q  <= ST_IDLE;
					end else begin
						pos_q   <= next_pos(pos_q, s_q);
						step_q  <= step_q + SLOT_CNT_W'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_DECIDE: begin
					if (store_full) begin
						done_q   <= 1'b1;
						rhash_q  <= '0;
						status_q <= STS_STORE_FULL;
						off_q    <= '0;
						state_q  <= ST_IDLE;
					end else begin
						wp_q     <= WP_W'(wp_sum);
						rhash_q  <= key_q;
						status_q <= STS_INSERTED;
						off_q    <= new_off;
						if (place_empty_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							// new key takes the stop slot; carry the displaced resident on
							car_q   <= res_q;
							d_q     <= d_q + SLOT_CNT_W'(1);
							pos_q   <= next_pos(stop_pos_q, s_q);
							state_q <= ST_I_RD;
						end
					end
				end
				ST_I_RD: begin
					state_q <= ST_I_CHK;
				end
				ST_I_CHK: begin
					res_q <= rd_data_q;
					if (rd_data_q.hash == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_I_DIST;
					end
				end
				ST_I_DIST: begin
					if (mod_done) begin
						if (dist_ext < d_q) begin
							car_q <= res_q;
							d_q   <= dist_ext + SLOT_CNT_W'(1);
						end else begin
							d_q <= d_q + SLOT_CNT_W'(1);
						end
						pos_q   <= next_pos(pos_q, s_q);
						state_q <= ST_I_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign returned_hash = rhash_q;
	assign status        = status_q;
	assign entry_offset  = off_q;

endmodule

// ===== tb/tb_robin_hood_hash_insert_core.sv =====
// ----------------------------------------------------------------------------
// tb_robin_hood_hash_insert_core
// Self-checking bench for the Robin Hood hash insert core. A local table
// model predicts every insert result: placement with displacement chains,
// duplicate lookups, table full and string store exhaustion. It checks each
// done strobe in order against the prediction, across many slot counts.
// ----------------------------------------------------------------------------
module tb_robin_hood_hash_insert_core;
	import rhh_pkg::*;

	localparam int CYCLE_LIMIT = 50_000_000;

	typedef struct packed {
		logic [KEY_W-1:0] hash;
		status_t          status;
		logic [OFF_W-1:0] offset;
	} insert_outcome_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             start         = 1'b0;
	logic [KEY_W-1:0] key_hash      = '0;
	logic [LEN_W-1:0] string_length = '0;
	logic             cfg_valid     = 1'b0;
	logic [CFG_W-1:0] cfg_data      = '0;
	logic             busy;
	logic             done;
	logic [KEY_W-1:0] returned_hash;
	logic [1:0]       status;
	logic [OFF_W-1:0] entry_offset;
	logic             cfg_ready;

	// table model
	bit [KEY_W-1:0] tbl_hash [TABLE_SLOTS];
	bit [OFF_W-1:0] tbl_off  [TABLE_SLOTS];
	int unsigned    store_ptr  = 0;
	int unsigned    slot_limit = SLOTS_RESET;

	insert_outcome_t  expected_results [$];
	logic [KEY_W-1:0] interned_keys [$];
	int               store_full_count = 0;
	int               mismatches       = 0;
	int               cycles           = 0;
	bit               sender_idles     = 1'b0;

	robin_hood_hash_insert_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.key_hash      (key_hash),
		.string_length (string_length),
		.done          (done),
		.returned_hash (returned_hash),
		.status        (status),
		.entry_offset  (entry_offset),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_robin_hood_hash_insert_core NOT OK");
			$finish;
		end
	end

	function automatic int unsigned live_slots();
		int unsigned s;
		s = slot_limit;
		if (s == 0) s = 1;
		if (s > TABLE_SLOTS) s = TABLE_SLOTS;
		return s;
	endfunction

	function automatic int unsigned probe_dist(bit [KEY_W-1:0] h, int unsigned pos,
			int unsigned s);
		return (pos + s - (h % s)) % s;
	endfunction

	function automatic insert_outcome_t predict_insert(logic [KEY_W-1:0] key,
			logic [LEN_W-1:0] len);
		insert_outcome_t res;
		int unsigned     s, home, pos, step, d, rd;
		bit [KEY_W-1:0]  c_hash, t_hash;
		bit [OFF_W-1:0]  c_off, t_off;
		bit              has_empty;
		res.hash   = '0;
		res.status = STS_TABLE_FULL;
		res.offset = '0;
		s = live_slots();
		if (key == '0) return res;
		home = key % s;
		// search along the probe path, no writes
		for (step = 0; step < s; step++) begin
			pos = (home + step) % s;
			if (tbl_hash[pos] == '0) break;
			if (tbl_hash[pos] == key) begin
				res.hash   = key;
				res.status = STS_PRESENT;
				res.offset = tbl_off[pos];
				return res;
			end
			if (probe_dist(tbl_hash[pos], pos, s) < step) break;
		end
		has_empty = 1'b0;
		for (pos = 0; pos < s; pos++) begin
			if (tbl_hash[pos] == '0) begin
				has_empty = 1'b1;
				break;
			end
		end
		if (!has_empty) return res;
		if (store_ptr + len + 1 > STORE_BYTES) begin
			res.status = STS_STORE_FULL;
			return res;
		end
		c_hash = key;
		c_off  = store_ptr[OFF_W-1:0];
		d      = 0;
		res.hash   = key;
		res.status = STS_INSERTED;
		res.offset = c_off;
		store_ptr += len + 1;
		// carry the poorer entry onward after each swap
		for (step = 0; step < s; step++) begin
			pos = (home + step) % s;
			if (tbl_hash[pos] == '0) begin
				tbl_hash[pos] = c_hash;
				tbl_off[pos]  = c_off;
				break;
			end
			rd = probe_dist(tbl_hash[pos], pos, s);
			if (rd < d) begin
				t_hash        = tbl_hash[pos];
				t_off         = tbl_off[pos];
				tbl_hash[pos] = c_hash;
				tbl_off[pos]  = c_off;
				c_hash        = t_hash;
				c_off         = t_off;
				d             = rd;
			end
			d++;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		insert_outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no transaction pending", returned_hash, '0);
			end else begin
				want = expected_results.pop_front();
				if (returned_hash !== want.hash)
					report_mismatch("returned_hash", returned_hash, want.hash);
				if (status !== want.status)
					report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
				if (entry_offset !== want.offset)
					report_mismatch("entry_offset", KEY_W'(entry_offset),
						KEY_W'(want.offset));
			end
		end
	end

	task automatic send_insert(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len);
		insert_outcome_t want;
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start         <= 1'b1;
		key_hash      <= key;
		string_length <= len;
		do @(posedge clk); while (busy !== 1'b0);
		want = predict_insert(key, len);
		expected_results.push_back(want);
		if (want.status == STS_INSERTED)
			interned_keys.push_back(key);
		else if (want.status == STS_STORE_FULL)
			store_full_count++;
	endtask

	// drop start and wait until every result is back and the core is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		slot_limit = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = $urandom;
		if (k == '0) k = 1;
		return k;
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return LEN_W'($urandom_range(0, 3));
		if (r < 95) return LEN_W'($urandom_range(0, 31));
		return LEN_W'($urandom_range(0, 255));
	endfunction

	// full slot count: field extremes, zero key, duplicate, shared home slots
	task automatic test_field_extremes();
		send_insert(32'hFFFF_FFFF, 8'hFF);
		send_insert(32'h0000_0001, 8'h00);
		send_insert(32'h0000_0000, 8'hAA);
		send_insert(32'h8000_0000, 8'h55);
		send_insert(32'hFFFF_FFFF, 8'h00);
		send_insert(32'd1025, 8'd3);
		send_insert(32'd2049, 8'd7);
	endtask

	// eight slots: residents get poorer, a displacement chain, then fill up
	task automatic test_probe_chains();
		settle();
		write_slot_count(11'd8);
		send_insert(32'd10, 8'd2);
		send_insert(32'd15, 8'd1);
		send_insert(32'd23, 8'd4);
		send_insert(32'd2049, 8'd9);
		send_insert(32'h8000_0000, 8'd0);
		send_insert(32'd16, 8'd5);
		send_insert(32'd24, 8'd6);
		send_insert(32'd32, 8'd1);
		send_insert(32'd24, 8'd0);
	endtask

	// one slot, zero slots (taken as one) and an oversized count (clipped)
	task automatic test_clipped_counts();
		settle();
		write_slot_count(11'd1);
		send_insert(32'd23, 8'd0);
		send_insert(32'd5, 8'd3);
		settle();
		write_slot_count(11'd0);
		send_insert(32'd7, 8'd1);
		settle();
		write_slot_count(11'h7FF);
		send_insert(32'hDEAD_BEEF, 8'hFF);
		send_insert(32'hDEAD_BEEF, 8'h10);
	endtask

	task automatic test_random_phases();
		int unsigned r, slots;
		int          n;
		logic [KEY_W-1:0] k;
		repeat (20) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 5) slots = $urandom_range(1, 16);
			else if (r < 8) slots = $urandom_range(17, 128);
			else slots = $urandom_range(129, 500);
			write_slot_count(CFG_W'(slots));
			sender_idles = ($urandom_range(0, 2) != 0);
			for (n = 0; n < 65; n++) begin
				r = $urandom_range(0, 99);
				if (r < 2) k = '0;
				else if (r < 27 && interned_keys.size() != 0)
					k = interned_keys[$urandom_range(0, interned_keys.size() - 1)];
				else k = fresh_key();
				send_insert(k, pick_length());
			end
		end
	endtask

	// long strings at the full slot count until the string store runs out
	task automatic test_store_exhaustion();
		int guard;
		logic [KEY_W-1:0] k;
		settle();
		sender_idles = 1'b0;
		write_slot_count(11'd1024);
		guard = 0;
		while (store_full_count < 24 && guard < 600) begin
			if ($urandom_range(0, 6) == 0 && interned_keys.size() != 0)
				k = interned_keys[$urandom_range(0, interned_keys.size() - 1)];
			else k = fresh_key();
			send_insert(k, LEN_W'($urandom_range(160, 255)));
			guard++;
		end
		send_insert(fresh_key(), 8'h00);
		settle();
		write_slot_count(11'd1);
		send_insert(fresh_key(), 8'h00);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_probe_chains();
		test_clipped_counts();
		test_random_phases();
		test_store_exhaustion();
		settle();
		repeat (50) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never returned", expected_results.size(), '0);
		if (mismatches == 0) begin
			$display("tb_robin_hood_hash_insert_core OK");
		end else begin
			$display("tb_robin_hood_hash_insert_core NOT OK");
		end
		$finish;
	end

endmodule
